// ===== rtl/assert_macros.svh =====
// assertion helpers for the neighbour liveness table
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property checked on the block clock, off while in reset
`define NLT_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed: label");

// condition that must never hold
`define NLT_ASSERT_NEVER(label, cond) \
  `NLT_ASSERT(label, !(cond))

`else

`define NLT_ASSERT(label, prop)
`define NLT_ASSERT_NEVER(label, cond)

`endif

`endif

// ===== rtl/nlt_pkg.sv =====
package nlt_pkg;

  // table geometry and field widths
  localparam int unsigned TableDepthDef = 16;
  localparam int unsigned IdWidth       = 64;
  localparam int unsigned StampWidth    = 16;
  localparam int unsigned CfgWidth      = 8;
  localparam int unsigned CfgIdxWidth   = 1;

  // configuration reset values
  localparam logic [CfgWidth-1:0] DeadIntervalRst = 8'd7;
  localparam logic [CfgWidth-1:0] NetworkTagRst   = 8'd101;

  // register indexes
  localparam logic [CfgIdxWidth-1:0] CfgIdxDead = 1'b0;
  localparam logic [CfgIdxWidth-1:0] CfgIdxTag  = 1'b1;

  // request commands
  localparam logic CmdHello = 1'b0;
  localparam logic CmdTick  = 1'b1;

  typedef enum logic [1:0] {
    KindAdded   = 2'd0,
    KindRemoved = 2'd1,
    KindDropped = 2'd2
  } nlt_kind_e;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StFlush
  } nlt_state_e;

  // write request into the entry store
  typedef struct packed {
    logic                  we_id;
    logic                  we_stamp;
    logic [IdWidth-1:0]    id;
    logic [StampWidth-1:0] stamp;
  } nlt_wr_t;

endpackage

// ===== rtl/nlt_store.sv =====
module nlt_store #(
  parameter int unsigned TABLE_DEPTH = nlt_pkg::TableDepthDef
) (
  input  logic                                clk_i,
  input  logic                                re_i,
  input  logic [$clog2(TABLE_DEPTH)-1:0]      raddr_i,
  input  logic [$clog2(TABLE_DEPTH)-1:0]      waddr_i,
  input  nlt_pkg::nlt_wr_t                    wr_i,
  output logic [nlt_pkg::IdWidth-1:0]         rd_id_o,
  output logic [nlt_pkg::StampWidth-1:0]      rd_stamp_o
);
  import nlt_pkg::*;

  logic [IdWidth-1:0]    mem_id    [TABLE_DEPTH];
  logic [StampWidth-1:0] mem_stamp [TABLE_DEPTH];
  logic [IdWidth-1:0]    rd_id_q;
  logic [StampWidth-1:0] rd_stamp_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_i.we_id) begin
      mem_id[waddr_i] <= wr_i.id;
    end
    if (wr_i.we_stamp) begin
      mem_stamp[waddr_i] <= wr_i.stamp;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rd_id_q    <= mem_id[raddr_i];
      rd_stamp_q <= mem_stamp[raddr_i];
    end
  end

  assign rd_id_o    = rd_id_q;
  assign rd_stamp_o = rd_stamp_q;

endmodule

// ===== rtl/nlt_cmp.sv =====
module nlt_cmp (
  input  logic                           tick_i,
  input  logic [nlt_pkg::IdWidth-1:0]    key_id_i,
  input  logic [nlt_pkg::IdWidth-1:0]    ent_id_i,
  input  logic [nlt_pkg::StampWidth-1:0] ent_stamp_i,
  input  logic [nlt_pkg::StampWidth-1:0] now_i,
  input  logic [nlt_pkg::CfgWidth-1:0]   dead_i,
  output logic                           hit_o
);
  import nlt_pkg::*;

  logic [StampWidth-1:0] age;

  // age wraps with the seconds counter
  assign age = now_i - ent_stamp_i;

  // hello: identifier match, tick: entry has gone silent too long
  always_comb begin
    if (tick_i) begin
      hit_o = age > {{(StampWidth-CfgWidth){1'b0}}, dead_i};
    end else begin
      hit_o = ent_id_i == key_id_i;
    end
  end

endmodule

// ===== rtl/nlt_ctrl.sv =====
module nlt_ctrl #(
  parameter int unsigned TABLE_DEPTH = nlt_pkg::TableDepthDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic                             cmd_i,
  input  logic [nlt_pkg::IdWidth-1:0]      neighbor_id_i,
  input  logic [nlt_pkg::CfgWidth-1:0]     dead_i,
  input  logic [nlt_pkg::CfgWidth-1:0]     tag_i,
  output logic                             busy_o,
  // entry store
  output logic                             re_o,
  output logic [$clog2(TABLE_DEPTH)-1:0]   raddr_o,
  output logic [$clog2(TABLE_DEPTH)-1:0]   waddr_o,
  output nlt_pkg::nlt_wr_t                 wr_o,
  input  logic [nlt_pkg::IdWidth-1:0]      rd_id_i,
  input  logic [nlt_pkg::StampWidth-1:0]   rd_stamp_i,
  // results
  output logic                             result_valid_o,
  output logic [1:0]                       event_kind_o,
  output logic [nlt_pkg::IdWidth-1:0]      reported_id_o,
  output logic [nlt_pkg::CfgWidth-1:0]     tag_out_o,
  output logic                             last_of_run_o
);
  import nlt_pkg::*;

  localparam int unsigned IdxW = $clog2(TABLE_DEPTH);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TABLE_DEPTH - 1);

  nlt_state_e            state_q, state_d;
  logic                  cmd_q, cmd_d;
  logic [IdWidth-1:0]    nid_q, nid_d;
  logic [IdxW-1:0]       rd_idx_q, rd_idx_d;
  logic                  rd_done_q, rd_done_d;
  logic                  chk_vld_q, chk_vld_d;
  logic [IdxW-1:0]       chk_idx_q, chk_idx_d;
  logic                  free_vld_q, free_vld_d;
  logic [IdxW-1:0]       free_idx_q, free_idx_d;
  logic                  pend_vld_q, pend_vld_d;
  logic [IdWidth-1:0]    pend_id_q, pend_id_d;
  logic [TABLE_DEPTH-1:0] valid_q, valid_d;
  logic [StampWidth-1:0] secs_q, secs_d;
  logic                  res_vld_q, res_vld_d;
  nlt_kind_e             res_kind_q, res_kind_d;
  logic [IdWidth-1:0]    res_id_q, res_id_d;
  logic [CfgWidth-1:0]   res_tag_q, res_tag_d;
  logic                  res_last_q, res_last_d;
  logic                  hit;
  logic                  ent_vld;
  logic [IdxW-1:0]       slot;

  // shared compare unit, one entry per cycle
  nlt_cmp u_cmp (
    .tick_i      (cmd_q == CmdTick),
    .key_id_i    (nid_q),
    .ent_id_i    (rd_id_i),
    .ent_stamp_i (rd_stamp_i),
    .now_i       (secs_q),
    .dead_i      (dead_i),
    .hit_o       (hit)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      rd_done_q  <= 1'b0;
      chk_vld_q  <= 1'b0;
      free_vld_q <= 1'b0;
      pend_vld_q <= 1'b0;
      valid_q    <= '0;
      secs_q     <= '0;
      res_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      rd_done_q  <= rd_done_d;
      chk_vld_q  <= chk_vld_d;
      free_vld_q <= free_vld_d;
      pend_vld_q <= pend_vld_d;
      valid_q    <= valid_d;
      secs_q     <= secs_d;
      res_vld_q  <= res_vld_d;
    end
  end

  // payload and indexes
  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    nid_q      <= nid_d;
    rd_idx_q   <= rd_idx_d;
    chk_idx_q  <= chk_idx_d;
    free_idx_q <= free_idx_d;
    pend_id_q  <= pend_id_d;
    res_kind_q <= res_kind_d;
    res_id_q   <= res_id_d;
    res_tag_q  <= res_tag_d;
    res_last_q <= res_last_d;
  end

  assign ent_vld = valid_q[chk_idx_q];
  assign slot    = free_vld_q ? free_idx_q : chk_idx_q;

  // sequencer
  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    nid_d      = nid_q;
    rd_idx_d   = rd_idx_q;
    rd_done_d  = rd_done_q;
    chk_vld_d  = 1'b0;
    chk_idx_d  = chk_idx_q;
    free_vld_d = free_vld_q;
    free_idx_d = free_idx_q;
    pend_vld_d = pend_vld_q;
    pend_id_d  = pend_id_q;
    valid_d    = valid_q;
    secs_d     = secs_q;
    res_vld_d  = 1'b0;
    res_kind_d = res_kind_q;
    res_id_d   = res_id_q;
    res_tag_d  = res_tag_q;
    res_last_d = res_last_q;
    re_o       = 1'b0;
    raddr_o    = rd_idx_q;
    waddr_o    = chk_idx_q;
    wr_o       = '0;

    case (state_q)
      StIdle: begin
        if (start_i) begin
          cmd_d      = cmd_i;
          nid_d      = neighbor_id_i;
          rd_idx_d   = '0;
          rd_done_d  = 1'b0;
          free_vld_d = 1'b0;
          pend_vld_d = 1'b0;
          if (cmd_i == CmdTick) begin
            secs_d = secs_q + StampWidth'(1);
          end
          state_d = StScan;
        end
      end

      StScan: begin
        // issue the next read
        if (!rd_done_q) begin
          re_o      = 1'b1;
          rd_idx_d  = rd_idx_q + IdxW'(1);
          rd_done_d = rd_idx_q == LastIdx;
          chk_vld_d = 1'b1;
          chk_idx_d = rd_idx_q;
        end
        // check the entry read last cycle
        if (chk_vld_q) begin
          if (cmd_q == CmdHello) begin
            if (ent_vld && hit) begin
              // known neighbour: refresh only
              wr_o.we_stamp = 1'b1;
              wr_o.stamp    = secs_q;
              waddr_o       = chk_idx_q;
              state_d       = StIdle;
            end else begin
              if (!ent_vld && !free_vld_q) begin
                free_vld_d = 1'b1;
                free_idx_d = chk_idx_q;
              end
              if (chk_idx_q == LastIdx) begin
                res_vld_d  = 1'b1;
                res_id_d   = nid_q;
                res_tag_d  = tag_i;
                res_last_d = 1'b1;
                if (free_vld_q || !ent_vld) begin
                  wr_o.we_id    = 1'b1;
                  wr_o.we_stamp = 1'b1;
                  wr_o.id       = nid_q;
                  wr_o.stamp    = secs_q;
                  waddr_o       = slot;
                  valid_d[slot] = 1'b1;
                  res_kind_d    = KindAdded;
                end else begin
                  res_kind_d = KindDropped;
                end
                state_d = StIdle;
              end
            end
          end else begin
            // expired entry: hold it back until we know whether it is the last
            if (ent_vld && hit) begin
              valid_d[chk_idx_q] = 1'b0;
              if (pend_vld_q) begin
                res_vld_d  = 1'b1;
                res_kind_d = KindRemoved;
                res_id_d   = pend_id_q;
                res_tag_d  = tag_i;
                res_last_d = 1'b0;
              end
              pend_vld_d = 1'b1;
              pend_id_d  = rd_id_i;
            end
            if (chk_idx_q == LastIdx) begin
              state_d = StFlush;
            end
          end
        end
      end

      StFlush: begin
        if (pend_vld_q) begin
          res_vld_d  = 1'b1;
          res_kind_d = KindRemoved;
          res_id_d   = pend_id_q;
          res_tag_d  = tag_i;
          res_last_d = 1'b1;
        end
        pend_vld_d = 1'b0;
        state_d    = StIdle;
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign busy_o         = state_q != StIdle;
  assign result_valid_o = res_vld_q;
  assign event_kind_o   = res_kind_q;
  assign reported_id_o  = res_id_q;
  assign tag_out_o      = res_tag_q;
  assign last_of_run_o  = res_last_q;

endmodule

// ===== rtl/neighbor_liveness_table_top.sv =====
// Neighbour liveness table. A request is taken when start_i is high and busy_o low;
// busy_o then stays high while the sequencer walks the entry store through its
// single registered read port, one entry per cycle into the shared compare unit:
// a hello stops early once its id is found, a tick walks every entry, then flushes.
// Results are one-cycle strobes on result_valid_o with no back-pressure: the
// receiver must take every strobe as it comes. A hello whose id is not found gives
// one result as busy_o falls, one that finds it gives none; a tick gives its
// removals in ascending slot order, the one marked last_of_run_o also as busy_o
// falls. The user must write configuration only while idle; it is not enforced.
`include "assert_macros.svh"

module neighbor_liveness_table_top #(
  parameter int unsigned TABLE_DEPTH = nlt_pkg::TableDepthDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic                                cmd_i,
  input  logic [nlt_pkg::IdWidth-1:0]         neighbor_id_i,
  input  logic                                cfg_we_i,
  input  logic [nlt_pkg::CfgIdxWidth-1:0]     cfg_idx_i,
  input  logic [nlt_pkg::CfgWidth-1:0]        cfg_wdata_i,
  output logic                                result_valid_o,
  output logic [1:0]                          event_kind_o,
  output logic [nlt_pkg::IdWidth-1:0]         reported_id_o,
  output logic [nlt_pkg::CfgWidth-1:0]        tag_out_o,
  output logic                                last_of_run_o
);
  import nlt_pkg::*;

  localparam int unsigned IdxW = $clog2(TABLE_DEPTH);

  logic [CfgWidth-1:0]   dead_q;
  logic [CfgWidth-1:0]   tag_q;
  logic                  re;
  logic [IdxW-1:0]       raddr;
  logic [IdxW-1:0]       waddr;
  nlt_wr_t               wr;
  logic [IdWidth-1:0]    rd_id;
  logic [StampWidth-1:0] rd_stamp;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dead_q <= DeadIntervalRst;
      tag_q  <= NetworkTagRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgIdxDead: dead_q <= cfg_wdata_i;
        CfgIdxTag:  tag_q  <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  nlt_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .cmd_i          (cmd_i),
    .neighbor_id_i  (neighbor_id_i),
    .dead_i         (dead_q),
    .tag_i          (tag_q),
    .busy_o         (busy_o),
    .re_o           (re),
    .raddr_o        (raddr),
    .waddr_o        (waddr),
    .wr_o           (wr),
    .rd_id_i        (rd_id),
    .rd_stamp_i     (rd_stamp),
    .result_valid_o (result_valid_o),
    .event_kind_o   (event_kind_o),
    .reported_id_o  (reported_id_o),
    .tag_out_o      (tag_out_o),
    .last_of_run_o  (last_of_run_o)
  );

  nlt_store #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_store (
    .clk_i      (clk_i),
    .re_i       (re),
    .raddr_i    (raddr),
    .waddr_i    (waddr),
    .wr_i       (wr),
    .rd_id_o    (rd_id),
    .rd_stamp_o (rd_stamp)
  );

  // an accepted request makes the block busy
  `NLT_ASSERT(a_start_busy, start_i && !busy_o |=> busy_o)
  // hello results are always single and final
  `NLT_ASSERT(a_hello_last, result_valid_o && event_kind_o != KindRemoved |-> last_of_run_o)
  // the final result of a run comes once the sequencer is back at rest
  `NLT_ASSERT_NEVER(a_last_idle, result_valid_o && last_of_run_o && busy_o)
  // more removals follow while the scan is still running
  `NLT_ASSERT(a_more_busy, result_valid_o && !last_of_run_o |-> busy_o)

endmodule
